FILE: rtl/i2cs_pkg.sv
package i2cs_pkg;

    // Operation codes
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_EVENT   = 2'd1;
    localparam logic [1:0] OP_ABORT   = 2'd2;

    // Transfer kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;

    // Bus event codes
    localparam logic [2:0] EV_START_SENT = 3'd0;
    localparam logic [2:0] EV_ADDR_ACKED = 3'd1;
    localparam logic [2:0] EV_BYTE_SENT  = 3'd2;
    localparam logic [2:0] EV_BYTE_RECV  = 3'd3;
    localparam logic [2:0] EV_NACK       = 3'd4;

    // Phase modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TX   = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;
    localparam logic [1:0] MODE_TXRX = 2'd3;

    // Status codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_BUSY  = 2'd1;
    localparam logic [1:0] ERR_ACK   = 2'd2;
    localparam logic [1:0] ERR_OTHER = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] transfer_kind;
        logic [6:0] target_address;
        logic [7:0] register_index;
        logic       register_present;
        logic [7:0] write_count;
        logic [7:0] read_count;
        logic [2:0] event_kind;
        logic [7:0] received_byte;
        logic [7:0] next_write_byte;
    } t_item;

    typedef struct packed {
        logic       start_cond;
        logic       stop_cond;
        logic       ack_on;
        logic       addr_send;
        logic       addr_read;
        logic       data_send;
        logic [7:0] data_byte;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic [1:0] status;
        logic       idle;
    } t_result;

endpackage

FILE: rtl/i2cs_core.sv
module i2cs_core
    import i2cs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic [1:0] r_phase_mode,     n_phase_mode;
    logic [1:0] r_latched_error,  n_latched_error;
    logic [7:0] r_tx_remaining,   n_tx_remaining;
    logic [7:0] r_rx_remaining,   n_rx_remaining;
    logic [6:0] r_slave_addr_reg, n_slave_addr_reg;
    logic [7:0] r_reg_addr_reg,   n_reg_addr_reg;
    logic       r_reg_pending,    n_reg_pending;
    logic       r_ack_level,      n_ack_level;

    logic       byte_done;
    logic       addr_dir;
    t_result    res;

    // Compute one step of the transfer sequence
    always_comb begin
        n_phase_mode     = r_phase_mode;
        n_latched_error  = r_latched_error;
        n_tx_remaining   = r_tx_remaining;
        n_rx_remaining   = r_rx_remaining;
        n_slave_addr_reg = r_slave_addr_reg;
        n_reg_addr_reg   = r_reg_addr_reg;
        n_reg_pending    = r_reg_pending;
        n_ack_level      = r_ack_level;
        byte_done        = 1'b0;
        addr_dir         = (r_phase_mode == MODE_RX);
        res              = '0;

        case (i_item.operation)
            OP_REQUEST: begin
                if (r_phase_mode != MODE_IDLE) begin
                    res.status = ERR_BUSY;
                end else begin
                    n_slave_addr_reg = i_item.target_address;
                    n_latched_error  = ERR_NONE;
                    res.start_cond   = 1'b1;
                    if (i_item.transfer_kind == KIND_READ) begin
                        n_tx_remaining = '0;
                        n_reg_pending  = 1'b0;
                        n_rx_remaining = i_item.read_count;
                        n_phase_mode   = MODE_RX;
                        if (i_item.read_count > 8'd1) n_ack_level = 1'b1;
                    end else begin
                        n_reg_addr_reg = i_item.register_index;
                        n_reg_pending  = i_item.register_present;
                        n_tx_remaining = i_item.write_count;
                        if (i_item.transfer_kind == KIND_WRITE) begin
                            n_rx_remaining = '0;
                            n_phase_mode   = MODE_TX;
                        end else begin
                            n_rx_remaining = i_item.read_count;
                            n_phase_mode   = MODE_TXRX;
                            if (i_item.read_count > 8'd1) n_ack_level = 1'b1;
                        end
                    end
                    res.status = ERR_NONE;
                end
            end
            OP_EVENT: begin
                if (r_phase_mode != MODE_IDLE) begin
                    case (i_item.event_kind)
                        EV_START_SENT: begin
                            res.addr_send = 1'b1;
                            res.addr_read = addr_dir;
                            res.data_byte = {r_slave_addr_reg, addr_dir};
                        end
                        EV_ADDR_ACKED: begin
                            if (r_phase_mode != MODE_RX) begin
                                if (r_reg_pending) begin
                                    res.data_send = 1'b1;
                                    res.data_byte = r_reg_addr_reg;
                                    n_reg_pending = 1'b0;
                                end else begin
                                    byte_done = 1'b1;
                                end
                            end
                        end
                        EV_BYTE_SENT: begin
                            byte_done = 1'b1;
                        end
                        EV_BYTE_RECV: begin
                            if (r_rx_remaining == 8'd0) begin
                                n_latched_error = ERR_OTHER;
                                res.stop_cond   = 1'b1;
                                n_ack_level     = 1'b0;
                                n_phase_mode    = MODE_IDLE;
                                res.done_res    = 1'b1;
                            end else begin
                                if (r_rx_remaining == 8'd2) begin
                                    n_ack_level = 1'b0;
                                end else if (r_rx_remaining == 8'd1) begin
                                    res.stop_cond = 1'b1;
                                    n_ack_level   = 1'b0;
                                    n_phase_mode  = MODE_IDLE;
                                    res.done_res  = 1'b1;
                                end
                                res.rx_valid   = 1'b1;
                                res.rx_data    = i_item.received_byte;
                                n_rx_remaining = r_rx_remaining - 8'd1;
                            end
                        end
                        EV_NACK: begin
                            n_latched_error = ERR_ACK;
                            res.stop_cond   = 1'b1;
                            n_ack_level     = 1'b0;
                            n_phase_mode    = MODE_IDLE;
                            res.done_res    = 1'b1;
                        end
                        default: begin
                            n_latched_error = ERR_OTHER;
                            res.stop_cond   = 1'b1;
                            n_ack_level     = 1'b0;
                            n_phase_mode    = MODE_IDLE;
                            res.done_res    = 1'b1;
                        end
                    endcase
                end
            end
            OP_ABORT: begin
                res.stop_cond = 1'b1;
                n_ack_level   = 1'b0;
                n_phase_mode  = MODE_IDLE;
            end
            default: begin
            end
        endcase

        // Advance after a byte went out: next byte, repeated start or stop
        if (byte_done) begin
            if (r_tx_remaining != 8'd0) begin
                res.data_send  = 1'b1;
                res.data_byte  = i_item.next_write_byte;
                n_tx_remaining = r_tx_remaining - 8'd1;
            end else if (r_phase_mode == MODE_TXRX) begin
                n_phase_mode   = MODE_RX;
                res.start_cond = 1'b1;
                if (r_rx_remaining > 8'd1) n_ack_level = 1'b1;
            end else begin
                res.stop_cond = 1'b1;
                n_ack_level   = 1'b0;
                n_phase_mode  = MODE_IDLE;
                res.done_res  = 1'b1;
            end
        end

        if (i_item.operation != OP_REQUEST) res.status = n_latched_error;
        res.ack_on = n_ack_level;
        res.idle   = (n_phase_mode == MODE_IDLE);
    end

    assign o_result = res;

    // Update control state when a request moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_mode     <= MODE_IDLE;
            r_latched_error  <= ERR_NONE;
            r_tx_remaining   <= '0;
            r_rx_remaining   <= '0;
            r_slave_addr_reg <= '0;
            r_reg_addr_reg   <= '0;
            r_reg_pending    <= 1'b0;
            r_ack_level      <= 1'b0;
        end else if (i_advance) begin
            r_phase_mode     <= n_phase_mode;
            r_latched_error  <= n_latched_error;
            r_tx_remaining   <= n_tx_remaining;
            r_rx_remaining   <= n_rx_remaining;
            r_slave_addr_reg <= n_slave_addr_reg;
            r_reg_addr_reg   <= n_reg_addr_reg;
            r_reg_pending    <= n_reg_pending;
            r_ack_level      <= n_ack_level;
        end
    end

endmodule

FILE: rtl/i2c_master_transfer_sequencer.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_operation .. i_next_write_byte
// output    o_out_valid / i_out_ready  o_start_cond .. o_idle
//
// An accepted request waits in the input register, which feeds the step logic;
// the step logic loads the result register. One request per cycle is sustained
// while the output side keeps up. Synchronous active-low reset empties both
// stages and returns the sequencer to idle. A stalled result holds the input
// register, which in turn drops o_in_ready.
module i2c_master_transfer_sequencer
    import i2cs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [1:0] i_transfer_kind,
    input  logic [6:0] i_target_address,
    input  logic [7:0] i_register_index,
    input  logic       i_register_present,
    input  logic [7:0] i_write_count,
    input  logic [7:0] i_read_count,
    input  logic [2:0] i_event_kind,
    input  logic [7:0] i_received_byte,
    input  logic [7:0] i_next_write_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_start_cond,
    output logic       o_stop_cond,
    output logic       o_ack_on,
    output logic       o_addr_send,
    output logic       o_addr_read,
    output logic       o_data_send,
    output logic [7:0] o_data_byte,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_data,
    output logic       o_done_res,
    output logic [1:0] o_status,
    output logic       o_idle
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result step_res;
    logic    advance;

    // Move the held request into the result stage when that stage frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Hold the input request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.operation        <= i_operation;
            r_in.transfer_kind    <= i_transfer_kind;
            r_in.target_address   <= i_target_address;
            r_in.register_index   <= i_register_index;
            r_in.register_present <= i_register_present;
            r_in.write_count      <= i_write_count;
            r_in.read_count       <= i_read_count;
            r_in.event_kind       <= i_event_kind;
            r_in.received_byte    <= i_received_byte;
            r_in.next_write_byte  <= i_next_write_byte;
        end
    end

    i2cs_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .o_result  (step_res)
    );

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_start_cond = r_out.start_cond;
    assign o_stop_cond  = r_out.stop_cond;
    assign o_ack_on     = r_out.ack_on;
    assign o_addr_send  = r_out.addr_send;
    assign o_addr_read  = r_out.addr_read;
    assign o_data_send  = r_out.data_send;
    assign o_data_byte  = r_out.data_byte;
    assign o_rx_valid   = r_out.rx_valid;
    assign o_rx_data    = r_out.rx_data;
    assign o_done_res   = r_out.done_res;
    assign o_status     = r_out.status;
    assign o_idle       = r_out.idle;

    // Address and data commands never go out together
    a_addr_data_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_addr_send && o_data_send))
        else $error("address and data send in one result");

    // A stop leaves the sequencer idle
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stop_cond |-> o_idle)
        else $error("stop without idle");

    // A start leaves the sequencer busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_cond |-> !o_idle)
        else $error("start while idle");

    // A blocked request stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("input request lost while blocked");

endmodule

FILE: tb/testbench.sv
module testbench;
    import i2cs_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] OP_NONE       = 2'd3;
    localparam logic [1:0] KIND_BOTH     = 2'd2;
    localparam logic [1:0] KIND_BOTH_ALT = 2'd3;
    localparam logic [2:0] EV_OTHER      = 3'd5;
    localparam logic [2:0] EV_RSVD_6     = 3'd6;
    localparam logic [2:0] EV_RSVD_7     = 3'd7;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_operation = '0;
    logic [1:0] i_transfer_kind = '0;
    logic [6:0] i_target_address = '0;
    logic [7:0] i_register_index = '0;
    logic       i_register_present = 1'b0;
    logic [7:0] i_write_count = '0;
    logic [7:0] i_read_count = '0;
    logic [2:0] i_event_kind = '0;
    logic [7:0] i_received_byte = '0;
    logic [7:0] i_next_write_byte = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_start_cond;
    logic       o_stop_cond;
    logic       o_ack_on;
    logic       o_addr_send;
    logic       o_addr_read;
    logic       o_data_send;
    logic [7:0] o_data_byte;
    logic       o_rx_valid;
    logic [7:0] o_rx_data;
    logic       o_done_res;
    logic [1:0] o_status;
    logic       o_idle;

    i2c_master_transfer_sequencer i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Sequencer state as the checker sees it
    logic [1:0] seq_mode = MODE_IDLE;
    logic [1:0] seq_err = ERR_NONE;
    logic [7:0] tx_left = '0;
    logic [7:0] rx_left = '0;
    logic [6:0] slave_addr = '0;
    logic [7:0] reg_addr = '0;
    logic       reg_due = 1'b0;
    logic       ack_en = 1'b0;
    t_result    step_out;

    t_result    expected_commands[$];
    t_result    last_result;
    int         items_sent = 0;
    int         error_count = 0;
    int         send_gap_pct = 0;
    int         recv_gap_pct = 0;
    int         ready_hold = 0;
    int         quiet_cycles = 0;

    function automatic void end_phase();
        step_out.stop_cond = 1'b1;
        ack_en = 1'b0;
        seq_mode = MODE_IDLE;
    endfunction

    function automatic void begin_phase(input logic [1:0] mode);
        seq_mode = mode;
        if (rx_left > 8'd1)
            ack_en = 1'b1;
        step_out.start_cond = 1'b1;
    endfunction

    function automatic void abort_on_error(input logic [1:0] code);
        seq_err = code;
        end_phase();
        step_out.done_res = 1'b1;
    endfunction

    // Send the next buffer byte, or move on once the write data is out
    function automatic void next_tx_byte(input logic [7:0] buf_byte);
        if (tx_left > 8'd0) begin
            step_out.data_send = 1'b1;
            step_out.data_byte = buf_byte;
            tx_left = tx_left - 8'd1;
        end else if (seq_mode == MODE_TXRX) begin
            begin_phase(MODE_RX);
        end else begin
            end_phase();
            step_out.done_res = 1'b1;
        end
    endfunction

    function automatic t_result next_bus_commands(input t_item it);
        step_out = '0;
        if (it.operation == OP_REQUEST) begin
            if (seq_mode != MODE_IDLE) begin
                step_out.status = ERR_BUSY;
            end else begin
                slave_addr = it.target_address;
                seq_err = ERR_NONE;
                if (it.transfer_kind == KIND_READ) begin
                    tx_left = '0;
                    reg_due = 1'b0;
                    rx_left = it.read_count;
                    begin_phase(MODE_RX);
                end else begin
                    reg_addr = it.register_index;
                    reg_due = it.register_present;
                    tx_left = it.write_count;
                    if (it.transfer_kind == KIND_WRITE) begin
                        rx_left = '0;
                        begin_phase(MODE_TX);
                    end else begin
                        rx_left = it.read_count;
                        begin_phase(MODE_TXRX);
                    end
                end
                step_out.status = ERR_NONE;
            end
        end else begin
            if (it.operation == OP_EVENT && seq_mode != MODE_IDLE) begin
                case (it.event_kind)
                    EV_START_SENT: begin
                        step_out.addr_send = 1'b1;
                        step_out.addr_read = (seq_mode == MODE_RX);
                        step_out.data_byte = {slave_addr, step_out.addr_read};
                    end
                    EV_ADDR_ACKED: begin
                        // Read phase: the receive side takes over, no command
                        if (seq_mode != MODE_RX) begin
                            if (reg_due) begin
                                step_out.data_send = 1'b1;
                                step_out.data_byte = reg_addr;
                                reg_due = 1'b0;
                            end else begin
                                next_tx_byte(it.next_write_byte);
                            end
                        end
                    end
                    EV_BYTE_SENT: next_tx_byte(it.next_write_byte);
                    EV_BYTE_RECV: begin
                        if (rx_left == 8'd0) begin
                            abort_on_error(ERR_OTHER);
                        end else begin
                            // Drop acknowledge before the last byte, stop on it
                            if (rx_left == 8'd2)
                                ack_en = 1'b0;
                            else if (rx_left == 8'd1)
                                end_phase();
                            step_out.rx_valid = 1'b1;
                            step_out.rx_data = it.received_byte;
                            rx_left = rx_left - 8'd1;
                            if (rx_left == 8'd0)
                                step_out.done_res = 1'b1;
                        end
                    end
                    EV_NACK: abort_on_error(ERR_ACK);
                    default: abort_on_error(ERR_OTHER);
                endcase
            end else if (it.operation == OP_ABORT) begin
                end_phase();
            end
            step_out.status = seq_err;
        end
        step_out.ack_on = ack_en;
        step_out.idle = (seq_mode == MODE_IDLE);
        return step_out;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.operation = 2'($urandom_range(0, 3));
        it.transfer_kind = 2'($urandom_range(0, 3));
        it.target_address = 7'($urandom_range(0, 127));
        it.register_index = 8'($urandom_range(0, 255));
        it.register_present = 1'($urandom_range(0, 1));
        it.write_count = 8'($urandom_range(0, 255));
        it.read_count = 8'($urandom_range(0, 255));
        it.event_kind = 3'($urandom_range(0, 7));
        it.received_byte = 8'($urandom_range(0, 255));
        it.next_write_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Offer one request and hold it until the sequencer takes it
    task automatic send_item(input t_item it);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_operation <= it.operation;
        i_transfer_kind <= it.transfer_kind;
        i_target_address <= it.target_address;
        i_register_index <= it.register_index;
        i_register_present <= it.register_present;
        i_write_count <= it.write_count;
        i_read_count <= it.read_count;
        i_event_kind <= it.event_kind;
        i_received_byte <= it.received_byte;
        i_next_write_byte <= it.next_write_byte;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        last_result = next_bus_commands(it);
        expected_commands.push_back(last_result);
        items_sent++;
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [6:0] addr,
                                input logic [7:0] regi, input logic present,
                                input logic [7:0] wcount, input logic [7:0] rcount);
        t_item it;
        it = '0;
        it.operation = OP_REQUEST;
        it.transfer_kind = kind;
        it.target_address = addr;
        it.register_index = regi;
        it.register_present = present;
        it.write_count = wcount;
        it.read_count = rcount;
        send_item(it);
    endtask

    task automatic send_bus(input logic [1:0] op, input logic [2:0] bus_event,
                            input logic [7:0] data);
        t_item it;
        it = '0;
        it.operation = op;
        it.event_kind = bus_event;
        it.received_byte = data;
        it.next_write_byte = data;
        send_item(it);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_commands.size() != 0)
            @(posedge i_clk);
    endtask

    // One transfer driven by plausible bus events, with some noise mixed in
    task automatic run_transfer();
        t_item      it;
        int         steps;
        int         roll;
        logic [2:0] next_event;
        it = random_item();
        it.operation = OP_REQUEST;
        if ($urandom_range(0, 19) != 0) begin
            it.write_count = 8'($urandom_range(0, 4));
            it.read_count = 8'($urandom_range(0, 4));
        end
        send_item(it);
        steps = 0;
        next_event = EV_START_SENT;
        while (seq_mode != MODE_IDLE) begin
            it = random_item();
            roll = $urandom_range(0, 99);
            if (steps > 40 || roll < 3) begin
                it.operation = OP_ABORT;
            end else if (roll < 6) begin
                it.operation = OP_REQUEST;
            end else if (roll < 8) begin
                it.operation = OP_NONE;
            end else begin
                it.operation = OP_EVENT;
                if (roll >= 13)
                    it.event_kind = next_event;
            end
            send_item(it);
            steps++;
            // Track which bus event the last command calls for
            if (last_result.start_cond)
                next_event = EV_START_SENT;
            else if (last_result.addr_send)
                next_event = last_result.addr_read ? EV_BYTE_RECV : EV_ADDR_ACKED;
            else if (last_result.data_send)
                next_event = EV_BYTE_SENT;
            else if (last_result.rx_valid)
                next_event = EV_BYTE_RECV;
        end
    endtask

    task automatic test_directed();
        send_gap_pct = 25;
        recv_gap_pct = 25;
        // Ignored while idle: event, unused operation; abort still stops
        send_bus(OP_EVENT, EV_START_SENT, 8'hFF);
        send_bus(OP_NONE, EV_NACK, 8'h00);
        send_bus(OP_ABORT, EV_START_SENT, 8'h00);
        // Write with register byte, refused request while busy
        send_request(KIND_WRITE, 7'h7F, 8'hFF, 1'b1, 8'd1, 8'd255);
        send_request(KIND_READ, 7'h00, 8'h00, 1'b0, 8'd0, 8'd3);
        send_bus(OP_EVENT, EV_START_SENT, 8'h00);
        send_bus(OP_EVENT, EV_ADDR_ACKED, 8'h00);
        send_bus(OP_EVENT, EV_BYTE_SENT, 8'hFF);
        send_bus(OP_EVENT, EV_BYTE_SENT, 8'h00);
        // Three-byte read: acknowledge drops before the last byte
        send_request(KIND_READ, 7'h00, 8'hFF, 1'b1, 8'd255, 8'd3);
        send_bus(OP_EVENT, EV_START_SENT, 8'h00);
        send_bus(OP_EVENT, EV_ADDR_ACKED, 8'h00);
        send_bus(OP_EVENT, EV_BYTE_RECV, 8'h00);
        send_bus(OP_EVENT, EV_BYTE_RECV, 8'hFF);
        send_bus(OP_EVENT, EV_BYTE_RECV, 8'hA5);
        // Write then read with nothing to read: byte received is an error
        send_request(KIND_BOTH, 7'h55, 8'h12, 1'b0, 8'd0, 8'd0);
        send_bus(OP_EVENT, EV_START_SENT, 8'h00);
        send_bus(OP_EVENT, EV_ADDR_ACKED, 8'h00);
        send_bus(OP_EVENT, EV_START_SENT, 8'h00);
        send_bus(OP_EVENT, EV_BYTE_RECV, 8'h3C);
        // Kind three acts as write then read; no acknowledge aborts it
        send_request(KIND_BOTH_ALT, 7'h2A, 8'h00, 1'b1, 8'd255, 8'd1);
        send_bus(OP_EVENT, EV_START_SENT, 8'h00);
        send_bus(OP_EVENT, EV_NACK, 8'h00);
        // Reserved event codes, then an abort mid-transfer with no error latched
        send_request(KIND_WRITE, 7'h01, 8'h80, 1'b0, 8'd0, 8'd0);
        send_bus(OP_EVENT, EV_RSVD_6, 8'h00);
        send_request(KIND_READ, 7'h40, 8'h00, 1'b0, 8'd0, 8'd255);
        send_bus(OP_EVENT, EV_RSVD_7, 8'h00);
        send_request(KIND_READ, 7'h33, 8'h00, 1'b0, 8'd0, 8'd2);
        send_bus(OP_ABORT, EV_OTHER, 8'h00);
    endtask

    task automatic test_random_transfers(input int count);
        int   target;
        t_item it;
        target = items_sent + count;
        while (items_sent < target) begin
            if (seq_mode == MODE_IDLE && $urandom_range(0, 99) < 8) begin
                it = random_item();
                send_item(it);
            end else begin
                run_transfer();
            end
        end
    endtask

    // Stall the result side long enough for the input to back up
    task automatic test_backpressure();
        ready_hold = 300;
        repeat (4) run_transfer();
    endtask

    task automatic test_pause_until_drained();
        run_transfer();
        wait_results_drained();
        run_transfer();
    endtask

    // Check each result against the oldest prediction; randomize ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_commands.size() == 0) begin
                $display("%0t: result with none expected", $time);
                error_count++;
            end else begin
                t_result want;
                t_result got;
                want = expected_commands.pop_front();
                got = {o_start_cond, o_stop_cond, o_ack_on, o_addr_send, o_addr_read,
                       o_data_send, o_data_byte, o_rx_valid, o_rx_data, o_done_res,
                       o_status, o_idle};
                if (got !== want) begin
                    $display("%0t: result mismatch, expected %h, got %h",
                             $time, want, got);
                    error_count++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // End the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        send_gap_pct = 12;
        recv_gap_pct = 78;
        test_random_transfers(200);
        send_gap_pct = 78;
        recv_gap_pct = 12;
        test_random_transfers(200);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_backpressure();
        test_pause_until_drained();
        test_random_transfers(150);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: i2c_master_transfer_sequencer.f
rtl/i2cs_pkg.sv
rtl/i2cs_core.sv
rtl/i2c_master_transfer_sequencer.sv
tb/testbench.sv
